@@ hdl/hrlf_pkg.sv @@
package hrlf_pkg;

    // Default width of the content length accumulator
    localparam int LEN_BITS_DEF = 32;

    // Length of the header name that carries the body length
    localparam int NAME_LEN = 14;

    // Character codes
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_UP_A  = 8'h41;
    localparam logic [7:0] CHR_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_GAP  = 8'h20;

    // Decimal radix of the length value
    localparam int RADIX = 10;

    // Framing status codes
    typedef enum logic [1:0] {
        ST_INCOMPLETE = 2'd0,
        ST_NO_LENGTH  = 2'd1,
        ST_FRAMED     = 2'd2,
        ST_MALFORMED  = 2'd3
    } t_status;

    // Progress through the CR LF CR LF header terminator
    typedef enum logic [1:0] {
        EM_IDLE   = 2'd0,
        EM_CR     = 2'd1,
        EM_CRLF   = 2'd2,
        EM_CRLFCR = 2'd3
    } t_end_match;

    // Position within one header line
    typedef enum logic [2:0] {
        PH_NAME    = 3'd0,
        PH_NAME_CR = 3'd1,
        PH_LEAD    = 3'd2,
        PH_DIGITS  = 3'd3,
        PH_TRAIL   = 3'd4,
        PH_SKIP    = 3'd5
    } t_phase;

    // Input word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_response;
    } t_in_word;

    // Output word
    typedef struct packed {
        logic [1:0]  framing_status;
        logic [31:0] expected_total;
        logic [31:0] bytes_seen;
        logic        message_complete;
        logic        over_length;
    } t_out_word;

    // Control from the frame core to the line parser
    typedef struct packed {
        logic       clear;
        logic       byte_evt;
        logic       end_evt;
        logic [7:0] data_byte;
    } t_line_ctrl;

    // Status from the line parser to the frame core
    typedef struct packed {
        logic length_found;
        logic pending_name_cr;
        logic malformed_evt;
    } t_line_stat;

    // Lowercase letter of the length header name at a position
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = 8'h63; // c
            4'd1:    ch = 8'h6F; // o
            4'd2:    ch = 8'h6E; // n
            4'd3:    ch = 8'h74; // t
            4'd4:    ch = 8'h65; // e
            4'd5:    ch = 8'h6E; // n
            4'd6:    ch = 8'h74; // t
            4'd7:    ch = 8'h2D; // -
            4'd8:    ch = 8'h6C; // l
            4'd9:    ch = 8'h65; // e
            4'd10:   ch = 8'h6E; // n
            4'd11:   ch = 8'h67; // g
            4'd12:   ch = 8'h74; // t
            4'd13:   ch = 8'h68; // h
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Fold an uppercase ASCII letter to lowercase
    function automatic logic [7:0] to_lower(input logic [7:0] c);
        logic [7:0] r;
        if (c inside {[CHR_UP_A:CHR_UP_Z]}) begin
            r = c + CASE_GAP;
        end else begin
            r = c;
        end
        return r;
    endfunction

endpackage

@@ hdl/hrlf_line_parser.sv @@
module hrlf_line_parser
    import hrlf_pkg::*;
#(
    parameter int LENGTH_BITS = LEN_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_line_ctrl             i_ctrl,
    output t_line_stat             o_stat,
    output logic [LENGTH_BITS-1:0] o_length
);

    localparam int WIDE = LENGTH_BITS + 4;

    t_phase                 r_phase,   n_phase;
    logic [3:0]             r_pos,     n_pos;
    logic [LENGTH_BITS-1:0] r_acc,     n_acc;
    logic                   r_found,   n_found;
    logic                   r_pending, n_pending;
    logic                   mal_evt;

    logic [7:0]      c;
    logic            is_blank;
    logic            is_digit;
    logic            is_cr;
    logic            pos_full;
    logic            name_hit;
    logic [WIDE-1:0] acc_wide;
    logic            acc_ovf;

    // Classify the incoming byte
    assign c        = i_ctrl.data_byte;
    assign is_blank = (c == CHR_SPACE) || (c == CHR_TAB);
    assign is_digit = c inside {[CHR_ZERO:CHR_NINE]};
    assign is_cr    = (c == CHR_CR);
    assign pos_full = (r_pos == 4'(NAME_LEN));
    assign name_hit = (r_pos < 4'(NAME_LEN)) && (to_lower(c) == name_char(r_pos));

    // Append the digit; anything above the accumulator range is an overflow
    assign acc_wide = {4'b0000, r_acc} * WIDE'(RADIX) + WIDE'(c[3:0]);
    assign acc_ovf  = |acc_wide[WIDE-1:LENGTH_BITS];

    // Next line state
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_acc     = r_acc;
        n_found   = r_found;
        n_pending = r_pending;
        if (i_ctrl.clear) begin
            n_phase   = PH_NAME;
            n_pos     = '0;
            n_acc     = '0;
            n_found   = 1'b0;
            n_pending = 1'b0;
        end else if (i_ctrl.end_evt) begin
            n_pending = (r_phase == PH_NAME_CR);
            n_phase   = PH_NAME;
            n_pos     = '0;
        end else if (i_ctrl.byte_evt) begin
            case (r_phase)
                PH_NAME: begin
                    if (c == CHR_COLON) begin
                        if (pos_full) begin
                            n_found = 1'b1;
                            n_acc   = '0;
                            n_phase = PH_LEAD;
                        end else begin
                            n_phase = PH_SKIP;
                        end
                    end else if (name_hit) begin
                        n_pos = r_pos + 4'd1;
                    end else if (pos_full && is_cr) begin
                        n_phase = PH_NAME_CR;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_NAME_CR: begin
                    n_phase = PH_SKIP;
                end
                PH_LEAD, PH_DIGITS: begin
                    if (is_digit) begin
                        if (acc_ovf) begin
                            n_phase = PH_SKIP;
                        end else begin
                            n_acc   = acc_wide[LENGTH_BITS-1:0];
                            n_phase = PH_DIGITS;
                        end
                    end else if (r_phase == PH_LEAD && is_blank) begin
                        n_phase = PH_LEAD;
                    end else if (r_phase == PH_DIGITS && (is_blank || is_cr)) begin
                        n_phase = PH_TRAIL;
                    end else begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_TRAIL: begin
                    if (!(is_blank || is_cr)) begin
                        n_phase = PH_SKIP;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    // Flag a malformed length line
    always_comb begin
        mal_evt = 1'b0;
        if (!i_ctrl.clear) begin
            if (i_ctrl.end_evt) begin
                mal_evt = (r_phase == PH_NAME && pos_full) || (r_phase == PH_LEAD);
            end else if (i_ctrl.byte_evt) begin
                case (r_phase)
                    PH_NAME: begin
                        // second length line
                        mal_evt = (c == CHR_COLON) && pos_full && r_found;
                    end
                    PH_LEAD, PH_DIGITS: begin
                        if (is_digit) begin
                            mal_evt = acc_ovf;
                        end else if (r_phase == PH_LEAD && is_blank) begin
                            mal_evt = 1'b0;
                        end else if (r_phase == PH_DIGITS && (is_blank || is_cr)) begin
                            mal_evt = 1'b0;
                        end else begin
                            mal_evt = 1'b1;
                        end
                    end
                    PH_TRAIL: begin
                        mal_evt = !(is_blank || is_cr);
                    end
                    default: begin
                        mal_evt = 1'b0;
                    end
                endcase
            end
        end
    end

    // Hold line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_NAME;
            r_pos     <= '0;
            r_acc     <= '0;
            r_found   <= 1'b0;
            r_pending <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_acc     <= n_acc;
            r_found   <= n_found;
            r_pending <= n_pending;
        end
    end

    assign o_stat.length_found    = r_found;
    assign o_stat.pending_name_cr = r_pending;
    assign o_stat.malformed_evt   = mal_evt;
    assign o_length               = r_acc;

endmodule

@@ hdl/hrlf_frame_core.sv @@
module hrlf_frame_core
    import hrlf_pkg::*;
#(
    parameter int LENGTH_BITS = LEN_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,
    input  t_in_word               i_data,
    input  t_line_stat             i_line,
    input  logic [LENGTH_BITS-1:0] i_length,
    output t_line_ctrl             o_ctrl,
    output t_out_word              o_result
);

    // Total limit is the smaller of the length range and 32 bits
    localparam int LIM_BITS = (LENGTH_BITS < 32) ? LENGTH_BITS : 32;
    localparam int SUM_W    = ((LENGTH_BITS > 32) ? LENGTH_BITS : 32) + 1;

    logic [31:0] r_count, n_count;
    t_end_match  r_em,    n_em;
    logic        r_ended, n_ended;
    logic        r_first, n_first;
    logic        r_mal,   n_mal;
    logic [31:0] r_exp,   n_exp;

    logic [31:0]      c_count;
    t_end_match       c_em;
    logic             c_ended;
    logic             c_first;
    logic             c_mal;
    logic [31:0]      c_exp;
    logic [7:0]       c;
    logic             start;
    logic             found;
    logic             line_go;
    logic             pend_mal;
    logic [SUM_W-1:0] total;
    logic             total_ovf;
    t_status          status;
    logic             framed;

    assign c     = i_data.data_byte;
    assign start = i_data.start_of_response;

    // Start of response drops all prior state before this byte
    assign c_count = start ? '0 : r_count;
    assign c_em    = start ? EM_IDLE : r_em;
    assign c_ended = start ? 1'b0 : r_ended;
    assign c_first = start ? 1'b0 : r_first;
    assign c_mal   = start ? 1'b0 : r_mal;
    assign c_exp   = start ? '0 : r_exp;

    // Offset after the terminator plus the length value
    assign total     = SUM_W'(n_count) + SUM_W'(i_length);
    assign total_ovf = |total[SUM_W-1:LIM_BITS];
    assign pend_mal  = c_mal || i_line.pending_name_cr;

    // Terminator search
    always_comb begin
        n_em  = c_em;
        found = 1'b0;
        if (!c_ended) begin
            case (c_em)
                EM_IDLE: n_em = (c == CHR_CR) ? EM_CR : EM_IDLE;
                EM_CR: begin
                    if (c == CHR_LF) begin
                        n_em = EM_CRLF;
                    end else if (c == CHR_CR) begin
                        n_em = EM_CR;
                    end else begin
                        n_em = EM_IDLE;
                    end
                end
                EM_CRLF: n_em = (c == CHR_CR) ? EM_CRLFCR : EM_IDLE;
                EM_CRLFCR: begin
                    found = (c == CHR_LF);
                    n_em  = (c == CHR_CR) ? EM_CR : EM_IDLE;
                end
                default: n_em = EM_IDLE;
            endcase
            if (found) begin
                n_em = EM_IDLE;
            end
        end
    end

    // Byte count, status line skip, header end, malformed flag and expected total
    always_comb begin
        n_count = (c_count == '1) ? c_count : c_count + 32'd1;
        n_ended = c_ended || found;
        n_first = c_first;
        n_mal   = c_mal || i_line.malformed_evt;
        n_exp   = c_exp;
        line_go = !c_ended && !found && c_first;
        if (!c_ended && !found && !c_first && c == CHR_LF) begin
            n_first = 1'b1;
        end
        if (found) begin
            n_mal = pend_mal;
            if (!pend_mal && i_line.length_found) begin
                if (total_ovf) begin
                    n_mal = 1'b1;
                end else begin
                    n_exp = total[31:0];
                end
            end
        end
    end

    // Drive the line parser
    assign o_ctrl.clear     = i_step && start;
    assign o_ctrl.byte_evt  = i_step && line_go && (c != CHR_LF);
    assign o_ctrl.end_evt   = i_step && line_go && (c == CHR_LF);
    assign o_ctrl.data_byte = c;

    // Status after this byte
    always_comb begin
        if (!n_ended) begin
            status = ST_INCOMPLETE;
        end else if (n_mal) begin
            status = ST_MALFORMED;
        end else if (i_line.length_found) begin
            status = ST_FRAMED;
        end else begin
            status = ST_NO_LENGTH;
        end
    end

    assign framed                    = (status == ST_FRAMED);
    assign o_result.framing_status   = status;
    assign o_result.expected_total   = framed ? n_exp : 32'd0;
    assign o_result.bytes_seen       = n_count;
    assign o_result.message_complete = framed && (n_count == n_exp);
    assign o_result.over_length      = framed && (n_count > n_exp);

    // Advance framing state on each word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_em    <= EM_IDLE;
            r_ended <= 1'b0;
            r_first <= 1'b0;
            r_mal   <= 1'b0;
            r_exp   <= '0;
        end else if (i_step) begin
            r_count <= n_count;
            r_em    <= n_em;
            r_ended <= n_ended;
            r_first <= n_first;
            r_mal   <= n_mal;
            r_exp   <= n_exp;
        end
    end

endmodule

@@ hdl/http_response_length_framer.sv @@
// Channel  Direction  Handshake                 Payload
// -------  ---------  ------------------------  -----------------------
// in       input      i_in_valid / o_in_ready   i_in_data  (t_in_word)
// out      output     o_out_valid / i_out_ready o_out_data (t_out_word)
//
// One word per cycle sustained while the output does not stall; each byte's
// result passes the input register, then the result register, to the output.
// The per-byte work is the framing update between the two registers; the
// length digit append and the total add set the longest path.
// Reset is synchronous, active low, and empties both registers.
// A stalled output holds its word; the input register still takes a word
// when the result register is about to drain.
module http_response_length_framer
    import hrlf_pkg::*;
#(
    parameter int LENGTH_BITS = LEN_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_data
);

    logic      r_in_valid;
    t_in_word  r_in_data;
    logic      r_out_valid;
    t_out_word r_out_data;

    logic                   advance;
    logic                   step;
    logic                   in_accept;
    t_line_ctrl             line_ctrl;
    t_line_stat             line_stat;
    logic [LENGTH_BITS-1:0] line_length;
    t_out_word              result;

    // Handshake between the two stages
    assign advance    = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;
    assign in_accept  = i_in_valid && o_in_ready;

    // Capture the input word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_data <= i_in_data;
        end
    end

    hrlf_line_parser #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_line_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (line_ctrl),
        .o_stat   (line_stat),
        .o_length (line_length)
    );

    hrlf_frame_core #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_frame_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_data   (r_in_data),
        .i_line   (line_stat),
        .i_length (line_length),
        .o_ctrl   (line_ctrl),
        .o_result (result)
    );

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Fields tied to framing are zero unless framed
    a_unframed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.framing_status != ST_FRAMED) |->
        (o_out_data.expected_total == 32'd0 && !o_out_data.message_complete &&
         !o_out_data.over_length))
        else $error("unframed result carries framing fields");

    // Complete and over length exclude each other
    a_complete_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.message_complete && o_out_data.over_length))
        else $error("complete and over length both set");

    // Every result counts at least its own byte
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.bytes_seen != 32'd0))
        else $error("result with zero byte count");

    // A word accepted into an empty pipe is offered once it passes the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !r_in_valid && !r_out_valid) |=> ##1 o_out_valid)
        else $error("result missing after accepted word");

endmodule
